FILE: hw/rtl/mtf_pkg.sv
// mtf_pkg: shared constants and code types for the move-to-front list core
// no dependencies; used by mtf_ram and move_to_front_list_core
package mtf_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_DELETE = 2'd1;
  localparam cmd_t CMD_ACCESS = 2'd2;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_FULL = 2'd2;

endpackage

FILE: hw/rtl/mtf_ram.sv
// mtf_ram: list entry storage, one write port and one read port with registered read data
// depends on mtf_pkg for the entry width
module mtf_ram #(
  parameter int DEPTH = mtf_pkg::CAPACITY_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [IW-1:0]               waddr,
  input  logic [mtf_pkg::VALUE_W-1:0] wdata,
  input  logic [IW-1:0]               raddr,
  output logic [mtf_pkg::VALUE_W-1:0] rdata
);

  logic [mtf_pkg::VALUE_W-1:0] mem_r [DEPTH];
  logic [mtf_pkg::VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/move_to_front_list_core.sv
// move_to_front_list_core: self-organizing list with insert, delete and move-to-front access
// depends on mtf_pkg and mtf_ram; one shared comparator and one mtf_ram under a small sequencer
// insert and unused codes complete directly from idle; delete and access first run a search pass,
// then on a hit a shift pass: delete closes the gap, access moves the entry to the front
// throughput: one transaction at a time while busy is low; out_valid strobes once, no stall
// reset: synchronous active-low rst_n empties the list; entry contents are not cleared
module move_to_front_list_core #(
  parameter int CAPACITY = mtf_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [mtf_pkg::CMD_W-1:0]     in_cmd,
  input  logic signed [mtf_pkg::VALUE_W-1:0] in_value,
  output logic                          out_valid,
  output logic [mtf_pkg::STATUS_W-1:0]  out_status,
  output logic [mtf_pkg::COUNT_W-1:0]   out_count
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT
  } state_t;

  state_t                      state_r;
  logic [CW-1:0]               count_r;
  logic [mtf_pkg::VALUE_W-1:0] val_r;
  logic                        is_acc_r;
  logic [CW-1:0]               i_r;
  logic                        cmp_vld_r;
  logic [IW-1:0]               cmp_idx_r;
  logic [IW-1:0]               rd_r;
  logic [IW-1:0]               wr_r;
  logic [CW-1:0]               n_r;
  logic                        sh_vld_r;
  logic                        out_valid_r;
  mtf_pkg::status_t            out_status_r;

  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [mtf_pkg::VALUE_W-1:0] ram_wdata;
  logic [IW-1:0]               ram_raddr;
  logic [mtf_pkg::VALUE_W-1:0] ram_rdata;

  logic                        accept;
  logic                        full;
  logic                        hit;

  assign accept = start && (state_r == S_IDLE);
  assign full   = (count_r >= CW'(CAPACITY));
  assign hit    = cmp_vld_r && (ram_rdata == val_r);

  mtf_ram #(
    .DEPTH (CAPACITY),
    .IW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_r;
    ram_wdata = ram_rdata;
    ram_raddr = (state_r == S_SEARCH) ? i_r[IW-1:0] : rd_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_cmd == mtf_pkg::CMD_INSERT) && !full) begin
          ram_we    = 1'b1;
          ram_waddr = count_r[IW-1:0];
          ram_wdata = in_value;
        end
      end
      S_SHIFT: begin
        if (sh_vld_r) begin
          ram_we = 1'b1;
        end else if ((n_r == '0) && is_acc_r) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = val_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      sh_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            val_r     <= in_value;
            is_acc_r  <= (in_cmd == mtf_pkg::CMD_ACCESS);
            i_r       <= '0;
            cmp_vld_r <= 1'b0;
            unique case (in_cmd)
              mtf_pkg::CMD_INSERT: begin
                out_valid_r <= 1'b1;
                if (full) begin
                  out_status_r <= mtf_pkg::ST_FULL;
                end else begin
                  out_status_r <= mtf_pkg::ST_OK;
                  count_r      <= count_r + CW'(1);
                end
              end
              mtf_pkg::CMD_DELETE, mtf_pkg::CMD_ACCESS: begin
                state_r <= S_SEARCH;
              end
              default: begin
                out_valid_r  <= 1'b1;
                out_status_r <= mtf_pkg::ST_MISS;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (hit) begin
            cmp_vld_r <= 1'b0;
            sh_vld_r  <= 1'b0;
            wr_r      <= cmp_idx_r;
            state_r   <= S_SHIFT;
            if (is_acc_r) begin
              rd_r <= cmp_idx_r - IW'(1);
              n_r  <= CW'(cmp_idx_r);
            end else begin
              rd_r <= cmp_idx_r + IW'(1);
              n_r  <= count_r - CW'(1) - CW'(cmp_idx_r);
            end
          end else if (i_r < count_r) begin
            cmp_vld_r <= 1'b1;
            cmp_idx_r <= i_r[IW-1:0];
            i_r       <= i_r + CW'(1);
          end else begin
            cmp_vld_r <= 1'b0;
            if (!cmp_vld_r) begin
              out_valid_r  <= 1'b1;
              out_status_r <= mtf_pkg::ST_MISS;
              state_r      <= S_IDLE;
            end
          end
        end
        S_SHIFT: begin
          if (sh_vld_r) begin
            wr_r <= is_acc_r ? (wr_r - IW'(1)) : (wr_r + IW'(1));
          end
          if (n_r != '0) begin
            rd_r     <= is_acc_r ? (rd_r - IW'(1)) : (rd_r + IW'(1));
            n_r      <= n_r - CW'(1);
            sh_vld_r <= 1'b1;
          end else begin
            sh_vld_r <= 1'b0;
            if (!sh_vld_r) begin
              if (!is_acc_r) begin
                count_r <= count_r - CW'(1);
              end
              out_valid_r  <= 1'b1;
              out_status_r <= mtf_pkg::ST_OK;
              state_r      <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = mtf_pkg::COUNT_W'(count_r);

endmodule

FILE: tb/sv/tb_move_to_front_list_core.sv
`timescale 1ns / 1ps
// tb_move_to_front_list_core: self-checking testbench for the move-to-front list core
// depends on mtf_pkg and move_to_front_list_core; a shadow list predicts every result,
// bursty command driver feeds the core, strobe monitor compares status and count per transaction
module tb_move_to_front_list_core;

  localparam int LIST_CAP   = mtf_pkg::CAPACITY_DEF;
  localparam int RAND_ITEMS = 1800;
  localparam int POOL_SIZE  = 24;
  localparam mtf_pkg::cmd_t CMD_UNUSED = 2'd3;

  typedef struct packed {
    mtf_pkg::cmd_t               cmd;
    logic [mtf_pkg::VALUE_W-1:0] value;
  } mtf_cmd_t;

  typedef struct packed {
    mtf_pkg::status_t            status;
    logic [mtf_pkg::COUNT_W-1:0] count;
  } mtf_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [mtf_pkg::CMD_W-1:0] in_cmd = '0;
  logic signed [mtf_pkg::VALUE_W-1:0] in_value = '0;
  logic busy;
  logic out_valid;
  logic [mtf_pkg::STATUS_W-1:0] out_status;
  logic [mtf_pkg::COUNT_W-1:0] out_count;

  mtf_cmd_t    cmd_backlog[$];
  mtf_result_t awaited_results[$];

  logic [mtf_pkg::VALUE_W-1:0] shadow_list[LIST_CAP];
  int shadow_len = 0;
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  mtf_cmd_t drive_item;

  move_to_front_list_core #(
    .CAPACITY(LIST_CAP)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_status(out_status),
    .out_count (out_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic queue_item(input mtf_pkg::cmd_t cmd, input logic [mtf_pkg::VALUE_W-1:0] value);
    mtf_cmd_t item;
    item.cmd = cmd;
    item.value = value;
    cmd_backlog.push_back(item);
  endtask

  task automatic predict_mtf(input mtf_cmd_t item, output mtf_result_t res);
    int pos;
    logic [mtf_pkg::VALUE_W-1:0] hit;
    mtf_pkg::status_t st;
    st = mtf_pkg::ST_MISS;
    pos = shadow_len;
    for (int i = shadow_len - 1; i >= 0; i--) begin
      if (shadow_list[i] == item.value) pos = i;
    end
    case (item.cmd)
      mtf_pkg::CMD_INSERT: begin
        if (shadow_len >= LIST_CAP) begin
          st = mtf_pkg::ST_FULL;
        end else begin
          shadow_list[shadow_len] = item.value;
          shadow_len++;
          st = mtf_pkg::ST_OK;
        end
      end
      mtf_pkg::CMD_DELETE: begin
        if (pos < shadow_len) begin
          for (int i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_len--;
          st = mtf_pkg::ST_OK;
        end
      end
      mtf_pkg::CMD_ACCESS: begin
        if (pos < shadow_len) begin
          hit = shadow_list[pos];
          for (int i = pos; i > 0; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[0] = hit;
          st = mtf_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
    res.status = st;
    res.count = shadow_len[mtf_pkg::COUNT_W-1:0];
  endtask

  // driver: bursts of transactions with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        drive_item = cmd_backlog.pop_front();
        in_cmd <= drive_item.cmd;
        in_value <= drive_item.value;
        start <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on acceptance, then check any result strobe
  always @(posedge clk) begin
    mtf_cmd_t    taken;
    mtf_result_t want;
    if (rst_n && start && !busy) begin
      taken.cmd = in_cmd;
      taken.value = in_value;
      predict_mtf(taken, want);
      awaited_results.push_back(want);
    end
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d count %0d", out_status, out_count);
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status || out_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d count %0d, got status %0d count %0d",
                     want.status, want.count, out_status, out_count);
        end
      end
    end
  end

  initial begin
    logic [mtf_pkg::VALUE_W-1:0] val_pool[POOL_SIZE];
    int ins_pct;
    int pick;
    mtf_pkg::cmd_t c;
    logic [mtf_pkg::VALUE_W-1:0] v;

    // empty list, unused code
    queue_item(mtf_pkg::CMD_DELETE, 32'd5);
    queue_item(mtf_pkg::CMD_ACCESS, 32'd5);
    queue_item(CMD_UNUSED, 32'd0);
    // extremes and a duplicate
    queue_item(mtf_pkg::CMD_INSERT, 32'h8000_0000);
    queue_item(mtf_pkg::CMD_INSERT, 32'h7fff_ffff);
    queue_item(mtf_pkg::CMD_INSERT, 32'h0000_0000);
    queue_item(mtf_pkg::CMD_INSERT, 32'hffff_ffff);
    queue_item(mtf_pkg::CMD_INSERT, 32'h7fff_ffff);
    for (int i = 0; i < LIST_CAP - 5; i++) queue_item(mtf_pkg::CMD_INSERT, 32'h100 + i);
    // full list, front, back, duplicates
    queue_item(mtf_pkg::CMD_INSERT, 32'h1234_5678);
    queue_item(mtf_pkg::CMD_ACCESS, 32'h8000_0000);
    queue_item(mtf_pkg::CMD_ACCESS, 32'h100 + LIST_CAP - 6);
    queue_item(mtf_pkg::CMD_ACCESS, 32'h7fff_ffff);
    queue_item(mtf_pkg::CMD_DELETE, 32'h7fff_ffff);
    queue_item(CMD_UNUSED, 32'hffff_ffff);
    queue_item(mtf_pkg::CMD_DELETE, 32'h5555_aaaa);

    for (int i = 0; i < POOL_SIZE; i++) val_pool[i] = $urandom;
    val_pool[0] = 32'h8000_0000;
    val_pool[1] = 32'h7fff_ffff;
    val_pool[2] = 32'h0000_0000;
    val_pool[3] = 32'hffff_ffff;
    ins_pct = 50;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 120 == 0) ins_pct = $urandom_range(15, 85);
      if ($urandom_range(0, 49) == 0) val_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 3) c = CMD_UNUSED;
      else if (pick < ins_pct) c = mtf_pkg::CMD_INSERT;
      else if ($urandom_range(0, 1) == 0) c = mtf_pkg::CMD_DELETE;
      else c = mtf_pkg::CMD_ACCESS;
      if ($urandom_range(0, 9) == 0) v = $urandom;
      else v = val_pool[$urandom_range(0, POOL_SIZE - 1)];
      queue_item(c, v);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (cmd_backlog.size() != 0 || start || awaited_results.size() != 0);
    repeat (2 * LIST_CAP + 8) @(negedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb_move_to_front_list_core passed");
    end else begin
      $display("tb_move_to_front_list_core failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_move_to_front_list_core failed");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mtf_pkg.sv
hw/rtl/mtf_ram.sv
hw/rtl/move_to_front_list_core.sv
tb/sv/tb_move_to_front_list_core.sv
